@@ rtl/core/scr_pkg.sv @@
package scr_pkg;

  // Sample and coefficient format.
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_W      = 16;
  localparam int FRAC        = 15;

  // Tap and history store geometry (depth is a power of two).
  localparam int TAP_AW   = 10;
  localparam int MAX_TAPS = 1 << TAP_AW;
  localparam int CNT_W    = TAP_AW + 1;

  // Datapath widths.
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int ACC_W   = PROD_W + TAP_AW + 1;
  localparam int CONV_W  = ACC_W - FRAC;
  localparam int DRY_W   = GAIN_W + 1 + SAMPLE_BITS;
  localparam int WET_W   = GAIN_W + 1 + CONV_W;
  localparam int MIX_W   = WET_W + 1;
  localparam int SHIFT_W = MIX_W - FRAC;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_DRY_GAIN  = 2'd1;
  localparam logic [1:0] REG_WET_GAIN  = 2'd2;
  localparam logic [1:0] REG_TAP_COUNT = 2'd3;

  // Item kinds carried in tuser.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TAP    = 1'b1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Control from the sequencer to one channel's MAC.
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic live;   // the read data of this cycle is a valid term
    logic accum;  // add the registered product
    logic mix;    // register the dry and wet products
  } mac_ctrl_t;

endpackage

@@ rtl/core/scr_mac.sv @@
module scr_mac (
  input  logic                clk,
  input  scr_pkg::mac_ctrl_t  ctrl,
  input  scr_pkg::sample_t    tap,
  input  scr_pkg::sample_t    hist,
  input  scr_pkg::sample_t    x,
  input  logic [15:0]         dry_gain,
  input  logic [15:0]         wet_gain,
  output scr_pkg::sample_t    result
);
  import scr_pkg::*;

  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [CONV_W-1:0]  conv15;
  logic signed [DRY_W-1:0]   dry_prod;
  logic signed [WET_W-1:0]   wet_prod;
  logic signed [MIX_W-1:0]   mix_sum;
  logic [SHIFT_W-1:0]        shifted;
  logic [SHIFT_W-SAMPLE_BITS:0] upper;

  // One tap product per cycle; dead terms contribute zero.
  always_ff @(posedge clk) begin
    if (ctrl.live) begin
      prod <= tap * hist;
    end else begin
      prod <= '0;
    end
  end

  // Accumulate the convolution sum exactly.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.accum) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign conv15 = $signed(acc[ACC_W-1:FRAC]);

  // Gain products, registered before the final sum.
  always_ff @(posedge clk) begin
    if (ctrl.mix) begin
      dry_prod <= $signed({1'b0, dry_gain}) * x;
      wet_prod <= $signed({1'b0, wet_gain}) * conv15;
    end
  end

  // Sum, floor shift and saturate to the sample width.
  assign mix_sum = $signed({{(MIX_W-DRY_W){dry_prod[DRY_W-1]}}, dry_prod})
                 + $signed({wet_prod[WET_W-1], wet_prod});
  assign shifted = mix_sum[MIX_W-1:FRAC];
  assign upper   = shifted[SHIFT_W-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      result = shifted[SAMPLE_BITS-1:0];
    end else if (shifted[SHIFT_W-1]) begin
      result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

@@ rtl/core/stereo_convolution_reverb_core.sv @@
// Channel   Direction  Beat contents
// s_*       in         tuser: action; tdata: left_in, right_in, tap_index, tap_left, tap_right
// m_*       out        tdata: left_out, right_out
// APB p*    in/out     enable @0x0, dry_gain @0x4, wet_gain @0x8, tap_count @0xC
//
// A tap beat leaves the block idle. A sample beat while disabled is passed through.
// A sample beat while enabled walks min(tap_count, 1024) taps, or none with a tap
// count of zero: both channels share one walk over the tap and history memories,
// one tap a cycle, then the drain, mix and done states.
// After reset the history is not cleared; a fill count masks slots not yet written.
// Input is taken only in the idle state; a finished result waits in the output
// register while the next beat is accepted, and a stalled output holds the done state.
module stereo_convolution_reverb_core (
  input  logic        clk,
  input  logic        rst,
  // Slave stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // left_in, right_in, tap_index, tap_left, tap_right, zero pad
  input  logic        s_tuser,   // action
  // Master stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // left_out, right_out
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scr_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_MIX   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]        state;
  logic              enable;
  logic [15:0]       dry_gain;
  logic [15:0]       wet_gain;
  logic [CNT_W-1:0]  tap_count;
  logic [TAP_AW-1:0] ptr;
  logic [TAP_AW-1:0] cur_ptr;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_run;
  logic [CNT_W-1:0]  k;
  logic              s1_valid;
  logic              s1_live;
  logic              s2_valid;
  logic              pass;
  sample_t           x_l;
  sample_t           x_r;

  logic [2*SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [2*SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];
  logic [2*SAMPLE_BITS-1:0] hist_rd;
  logic [2*SAMPLE_BITS-1:0] tap_rd;
  logic [TAP_AW-1:0]        hist_raddr;

  logic              in_acc;
  logic              cfg_wr;
  logic              out_free;
  sample_t           in_l;
  sample_t           in_r;
  logic [TAP_AW-1:0] in_idx;
  mac_ctrl_t         ctrl;
  sample_t           res_l;
  sample_t           res_r;

  // Input beat fields.
  assign in_l   = s_tdata[15:0];
  assign in_r   = s_tdata[31:16];
  assign in_idx = s_tdata[41:32];

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !m_tvalid || m_tready;
  assign pready   = 1'b1;
  assign n_eff    = (tap_count > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : tap_count;

  // Configuration registers and read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b0;
      dry_gain  <= 16'd32768;
      wet_gain  <= 16'd19661;
      tap_count <= CNT_W'(MAX_TAPS);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ENABLE:    enable    <= pwdata[0];
        REG_DRY_GAIN:  dry_gain  <= pwdata[15:0];
        REG_WET_GAIN:  wet_gain  <= pwdata[15:0];
        REG_TAP_COUNT: tap_count <= pwdata[CNT_W-1:0];
        default:       enable    <= enable;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENABLE:    prdata = {31'd0, enable};
      REG_DRY_GAIN:  prdata = {16'd0, dry_gain};
      REG_WET_GAIN:  prdata = {16'd0, wet_gain};
      REG_TAP_COUNT: prdata = {{(32-CNT_W){1'b0}}, tap_count};
      default:       prdata = '0;
    endcase
  end

  // History write pointer and fill count; turning the effect off empties the history.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      fill <= '0;
    end else if (cfg_wr && paddr[3:2] == REG_ENABLE && enable && !pwdata[0]) begin
      ptr  <= '0;
      fill <= '0;
    end else if (in_acc && s_tuser == ACT_SAMPLE && enable) begin
      ptr <= ptr + 1'b1;
      if (fill != CNT_W'(MAX_TAPS)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Memories: written on accepted beats (history only while enabled); read data is registered before the MACs.
  assign hist_raddr = cur_ptr - k[TAP_AW-1:0];

  always_ff @(posedge clk) begin
    if (in_acc && s_tuser == ACT_SAMPLE && enable) begin
      hist_mem[ptr] <= {in_r, in_l};
    end
    hist_rd <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && s_tuser == ACT_TAP) begin
      tap_mem[in_idx] <= {s_tdata[73:58], s_tdata[57:42]};
    end
    tap_rd <= tap_mem[k[TAP_AW-1:0]];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      k        <= '0;
      s1_valid <= 1'b0;
      s1_live  <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_RUN);
      s1_live  <= (state == ST_RUN) && (k < fill);
      s2_valid <= s1_valid;
      case (state)
        ST_IDLE: begin
          k <= '0;
          if (in_acc && s_tuser == ACT_SAMPLE) begin
            if (!enable) begin
              state <= ST_DONE;
            end else if (n_eff == '0) begin
              state <= ST_DRAIN;
            end else begin
              state <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (k + 1'b1 == n_run) begin
            state <= ST_DRAIN;
          end
          k <= k + 1'b1;
        end
        ST_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output valid: set when a result is loaded, cleared when the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Per-item operands captured on acceptance.
  always_ff @(posedge clk) begin
    if (in_acc && s_tuser == ACT_SAMPLE) begin
      x_l     <= in_l;
      x_r     <= in_r;
      pass    <= !enable;
      cur_ptr <= ptr;
      n_run   <= n_eff;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      m_tdata <= pass ? {x_r, x_l} : {res_r, res_l};
    end
  end

  assign ctrl.clear = in_acc;
  assign ctrl.live  = s1_live;
  assign ctrl.accum = s2_valid;
  assign ctrl.mix   = (state == ST_MIX);

  scr_mac u_mac_l (
    .clk      (clk),
    .ctrl     (ctrl),
    .tap      (tap_rd[SAMPLE_BITS-1:0]),
    .hist     (hist_rd[SAMPLE_BITS-1:0]),
    .x        (x_l),
    .dry_gain (dry_gain),
    .wet_gain (wet_gain),
    .result   (res_l)
  );

  scr_mac u_mac_r (
    .clk      (clk),
    .ctrl     (ctrl),
    .tap      (tap_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .hist     (hist_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .x        (x_r),
    .dry_gain (dry_gain),
    .wet_gain (wet_gain),
    .result   (res_r)
  );

endmodule

@@ rtl/core/scr_checker.sv @@
module scr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  import scr_pkg::*;

  // A stalled output beat holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat changed while stalled");

  // Reset leaves the block idle with nothing to deliver.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  // A tap beat never produces a result.
  a_tap_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == ACT_TAP && !m_tvalid |=> !m_tvalid)
    else $error("result appeared after a tap beat");

  // A sample beat keeps the input closed while it is processed.
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == ACT_SAMPLE |=> !s_tready)
    else $error("input taken during sample processing");

endmodule

bind stereo_convolution_reverb_core scr_checker u_scr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
